@@ hw/rtl/mfre_pkg.sv @@
// ----------------------------------------------------------------------------
// mfre_pkg
// Shared types, constants and edge-mask functions for the framebuffer engine.
// ----------------------------------------------------------------------------
package mfre_pkg;

  localparam int unsigned DefFrameWidth  = 128;
  localparam int unsigned DefFrameHeight = 64;
  localparam int unsigned StoreDepth     = 1024;
  localparam int unsigned StoreAw        = 10;
  localparam logic [7:0]  WrapLimit      = 8'd64;
  localparam logic [7:0]  CmdBase        = 8'h80;
  localparam logic [5:0]  ScanWords      = 6'd32;

  typedef enum logic [2:0] {
    OpSetPixel  = 3'd0,
    OpReadPixel = 3'd1,
    OpHspan     = 3'd2,
    OpVline     = 3'd3,
    OpClear     = 3'd4,
    OpScanRow   = 3'd5,
    OpRsvd6     = 3'd6,
    OpRsvd7     = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StPaintRd,
    StPaintWr,
    StPixRd,
    StPixOut,
    StCmd0,
    StCmd1,
    StScanRd,
    StScanOut
  } state_e;

  // Leftmost pixel is bit 7.
  function automatic logic [7:0] start_mask(input logic [2:0] b);
    start_mask = 8'hff >> b;
  endfunction

  function automatic logic [7:0] end_mask(input logic [2:0] b);
    end_mask = 8'hff << (3'd7 - b);
  endfunction

endpackage

@@ hw/rtl/mono_framebuffer_raster_engine_unit.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_raster_engine_unit
// One-bit framebuffer with pixel, span, line, clear and row-pair scan-out,
// run by a small sequencer around one read-modify-write memory port.
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// in      | valid_i   | stall_o   | operation_i x_pos_i y_pos_i run_length_i color_i
// out     | valid_o   | stall_i   | data_byte_o is_command_o last_o
//
// Every touched byte is read, then written, on the single memory port.
// Clear sweeps the store at one byte a cycle. Read pixel reads one byte;
// scan row sends two command words, then reads and sends each data word in
// turn. Any output stall holds pixel and scan output.
// After reset the same clearing pass runs with stall_o high.
// stall_i only holds the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine_unit #(
  parameter int unsigned FRAME_WIDTH  = mfre_pkg::DefFrameWidth,
  parameter int unsigned FRAME_HEIGHT = mfre_pkg::DefFrameHeight
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic [7:0] run_length_i,
  input  logic       color_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] data_byte_o,
  output logic       is_command_o,
  output logic       last_o
);
  import mfre_pkg::*;

  localparam logic [8:0]  LimW = 9'(FRAME_WIDTH);
  localparam logic [8:0]  LimH = 9'(FRAME_HEIGHT);
  localparam logic [15:0] FwMul = 16'(FRAME_WIDTH);

  state_e state_q, state_d;

  logic [7:0] mem_q [StoreDepth];
  logic [7:0] rd_q;

  logic [StoreAw-1:0] clr_q, clr_d;
  logic [5:0] scn_q, scn_d;
  logic [7:0] cur_q, cur_d, end_q, end_d, bs_q, bs_d;
  logic [7:0] x_q, x_d, y_q, y_d;
  logic [2:0] smi_q, smi_d, emi_q, emi_d;
  logic       hsp_q, hsp_d, on_q, on_d, pix_q, pix_d;

  logic       ov_q, ov_d, cmd_q, cmd_d, last_q, last_d;
  logic [7:0] dat_q, dat_d;

  logic               we;
  logic [StoreAw-1:0] wa, ra;
  logic [7:0]         wd;

  // trim / clamp of the incoming run
  logic       hs_in;
  logic [8:0] lim;
  logic [7:0] s0, p, s2, r2, e;
  logic       beyond, kill;

  logic       out_free, accept;
  logic [7:0] pmask;
  logic [15:0] addr_w;

  assign out_free = !ov_q || !stall_i;
  assign accept   = valid_i && !stall_o;
  assign stall_o  = (state_q != StIdle);

  always_comb begin
    hs_in  = (operation_i == OpHspan);
    lim    = hs_in ? LimW : LimH;
    s0     = hs_in ? x_pos_i : y_pos_i;
    p      = 8'd0 - s0;
    beyond = ({1'b0, s0} >= lim);
    kill   = beyond && ((p >= run_length_i) || (p >= WrapLimit));
    s2     = beyond ? 8'd0 : s0;
    r2     = beyond ? (run_length_i - p) : run_length_i;
    e      = s2 + r2 - 8'd1;
    if ({1'b0, e} >= lim) begin
      e = 8'(lim - 9'd1);
    end
  end

  // byte address of the current step
  always_comb begin
    if (hsp_q) begin
      addr_w = ((16'(y_q) * FwMul) >> 3) + 16'(cur_q);
    end else begin
      addr_w = (16'(cur_q) * FwMul + 16'(x_q)) >> 3;
    end
    if (!hsp_q) begin
      pmask = 8'h80 >> x_q[2:0];
    end else if (cur_q == bs_q && cur_q == end_q) begin
      pmask = start_mask(smi_q) & end_mask(emi_q);
    end else if (cur_q == bs_q) begin
      pmask = start_mask(smi_q);
    end else if (cur_q == end_q) begin
      pmask = end_mask(emi_q);
    end else begin
      pmask = 8'hff;
    end
  end

  // next state and sequencer registers
  always_comb begin
    state_d = state_q;
    clr_d = clr_q; scn_d = scn_q; cur_d = cur_q; end_d = end_q; bs_d = bs_q;
    x_d = x_q; y_d = y_q; smi_d = smi_q; emi_d = emi_q;
    hsp_d = hsp_q; on_d = on_q; pix_d = pix_q;
    ov_d = ov_q && stall_i;
    dat_d = dat_q; cmd_d = cmd_q; last_d = last_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          x_d = x_pos_i; y_d = y_pos_i; on_d = color_i; hsp_d = 1'b0;
          cur_d = y_pos_i; end_d = y_pos_i;
          priority case (operation_i)
            OpSetPixel: begin
              if ({1'b0, x_pos_i} < LimW && {1'b0, y_pos_i} < LimH) begin
                state_d = StPaintRd;
              end
            end
            OpReadPixel: begin
              pix_d = ({1'b0, x_pos_i} < LimW && {1'b0, y_pos_i} < LimH);
              state_d = pix_d ? StPixRd : StPixOut;
            end
            OpHspan: begin
              hsp_d = 1'b1;
              bs_d = s2 >> 3; cur_d = s2 >> 3; end_d = e >> 3;
              smi_d = s2[2:0]; emi_d = e[2:0];
              if ({1'b0, y_pos_i} < LimH && !kill) begin
                state_d = StPaintRd;
              end
            end
            OpVline: begin
              cur_d = s2; end_d = e;
              if ({1'b0, x_pos_i} < LimW && !kill && e >= s2) begin
                state_d = StPaintRd;
              end
            end
            OpClear: begin
              clr_d = '0;
              state_d = StClear;
            end
            OpScanRow: begin
              scn_d = '0;
              state_d = StCmd0;
            end
            default: ;
          endcase
        end
      end
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == StoreAw'(StoreDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StPaintRd: state_d = StPaintWr;
      StPaintWr: begin
        if (cur_q == end_q) begin
          state_d = StIdle;
        end else begin
          cur_d = (end_q < cur_q) ? end_q : cur_q + 8'd1;
          state_d = StPaintRd;
        end
      end
      StPixRd: state_d = StPixOut;
      StPixOut: begin
        if (out_free) begin
          ov_d = 1'b1; cmd_d = 1'b0; last_d = 1'b1;
          dat_d = pix_q ? 8'(rd_q[3'd7 - x_q[2:0]]) : 8'd0;
          state_d = StIdle;
        end
      end
      StCmd0: begin
        if (out_free) begin
          ov_d = 1'b1; cmd_d = 1'b1; last_d = 1'b0;
          dat_d = CmdBase | {3'd0, y_q[4:0]};
          state_d = StCmd1;
        end
      end
      StCmd1: begin
        if (out_free) begin
          ov_d = 1'b1; cmd_d = 1'b1; last_d = 1'b0;
          dat_d = CmdBase;
          state_d = StScanRd;
        end
      end
      StScanRd: state_d = StScanOut;
      StScanOut: begin
        if (out_free) begin
          ov_d = 1'b1; cmd_d = 1'b0; dat_d = rd_q;
          last_d = (scn_q == ScanWords - 6'd1);
          scn_d = scn_q + 6'd1;
          state_d = last_d ? StIdle : StScanRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = addr_w[StoreAw-1:0];
    wd = on_q ? (rd_q | pmask) : (rd_q & ~pmask);
    ra = addr_w[StoreAw-1:0];
    unique case (state_q)
      StClear: begin
        we = 1'b1; wa = clr_q; wd = 8'd0;
      end
      StPaintWr: we = 1'b1;
      // keep the scan address while the output waits so rd_q holds
      StScanRd, StScanOut: ra = {scn_q[4], y_q[4:0], scn_q[3:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scn_q <= scn_d; cur_q <= cur_d; end_q <= end_d; bs_q <= bs_d;
    x_q <= x_d; y_q <= y_d; smi_q <= smi_d; emi_q <= emi_d;
    hsp_q <= hsp_d; on_q <= on_d; pix_q <= pix_d;
    dat_q <= dat_d; cmd_q <= cmd_d; last_q <= last_d;
  end

  assign valid_o      = ov_q;
  assign data_byte_o  = dat_q;
  assign is_command_o = cmd_q;
  assign last_o       = last_q;

endmodule
